>>> rtl/snnl_pkg.sv
package snnl_pkg;

    // Number of cells in the chain
    localparam int CAPACITY = 16;
    // Bits for a position in the chain and for the fill count
    localparam int POS_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    // A read emits at most this many entries
    localparam int READ_MAX = (CAPACITY < 16) ? CAPACITY : 16;

    localparam int DIST_W = 32;
    localparam int IDX_W  = 16;
    localparam int RANK_W = 4;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_READ   = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    // What a cell loads at the next edge
    typedef enum logic [1:0] {
        CELL_HOLD      = 2'd0,
        CELL_LOAD_NEW  = 2'd1,
        CELL_TAKE_PREV = 2'd2,
        CELL_TAKE_NEXT = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
    } cell_ctrl_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } state_t;

endpackage

>>> rtl/snnl_cell.sv
module snnl_cell (
    input  logic                          clk,
    input  snnl_pkg::cell_ctrl_t          ctrl,
    input  logic [snnl_pkg::DIST_W-1:0]   new_dist,
    input  logic [snnl_pkg::IDX_W-1:0]    new_idx,
    input  logic [snnl_pkg::DIST_W-1:0]   prev_dist,
    input  logic [snnl_pkg::IDX_W-1:0]    prev_idx,
    input  logic [snnl_pkg::DIST_W-1:0]   next_dist,
    input  logic [snnl_pkg::IDX_W-1:0]    next_idx,
    output logic [snnl_pkg::DIST_W-1:0]   held_dist,
    output logic [snnl_pkg::IDX_W-1:0]    held_idx,
    output logic                          ge
);

    logic [snnl_pkg::DIST_W-1:0] dist_reg, dist_next;
    logic [snnl_pkg::IDX_W-1:0]  idx_reg, idx_next;

    // Compare the new distance against the held one
    assign ge = (new_dist <= dist_reg);

    // Pick the next contents: hold, take the new pair, or take a neighbor's
    always_comb
    begin
        dist_next = dist_reg;
        idx_next  = idx_reg;
        case (ctrl.op)
            snnl_pkg::CELL_LOAD_NEW:
            begin
                dist_next = new_dist;
                idx_next  = new_idx;
            end
            snnl_pkg::CELL_TAKE_PREV:
            begin
                dist_next = prev_dist;
                idx_next  = prev_idx;
            end
            snnl_pkg::CELL_TAKE_NEXT:
            begin
                dist_next = next_dist;
                idx_next  = next_idx;
            end
            default:
            begin
                dist_next = dist_reg;
                idx_next  = idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= dist_next;
        idx_reg  <= idx_next;
    end

    assign held_dist = dist_reg;
    assign held_idx  = idx_reg;

endmodule

>>> rtl/sorted_nearest_neighbor_list_unit.sv
// Sorted candidate list held in a chain of CAPACITY cells, nearest first.
// An item is taken when start is high and busy is low. For an insert, every
// cell compares the new distance at once and the cells at and after the
// insertion point shift by one, so inserts and clears can follow each other
// in every cycle. The insert result is registered and appears on the result
// ports in the cycle after the item is taken. A read rotates the whole chain
// through cell 0, one cell a cycle, and raises busy until the rotation ends;
// results come out one per cycle for the stored entries (at most 16), the
// last one marked by last_of_run. A read of an empty list gives a single
// all-zero result with last_of_run set and does not raise busy. Clear and
// unused commands give no result. Results are shown for exactly one cycle
// with strobe high; the receiver cannot stall.
module sorted_nearest_neighbor_list_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    command,
    input  logic [snnl_pkg::DIST_W-1:0]   distance,
    input  logic [snnl_pkg::IDX_W-1:0]    candidate_index,
    output logic                          strobe,
    output logic                          entry_valid,
    output logic [snnl_pkg::RANK_W-1:0]   rank,
    output logic [snnl_pkg::IDX_W-1:0]    ranked_index,
    output logic [snnl_pkg::DIST_W-1:0]   ranked_distance,
    output logic                          dropped,
    output logic                          last_of_run
);

    localparam int CAP = snnl_pkg::CAPACITY;

    snnl_pkg::state_t                 state_reg, state_next;
    logic [snnl_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [snnl_pkg::POS_W-1:0]       rot_reg, rot_next;

    logic                             strobe_reg, strobe_next;
    logic                             valid_reg, valid_next;
    logic [snnl_pkg::RANK_W-1:0]      rank_reg, rank_next;
    logic [snnl_pkg::IDX_W-1:0]       ridx_reg, ridx_next;
    logic [snnl_pkg::DIST_W-1:0]      rdist_reg, rdist_next;
    logic                             drop_reg, drop_next;
    logic                             last_reg, last_next;

    snnl_pkg::cell_ctrl_t             ctrl   [CAP];
    logic [snnl_pkg::DIST_W-1:0]      c_dist [CAP];
    logic [snnl_pkg::IDX_W-1:0]       c_idx  [CAP];
    logic [CAP-1:0]                   c_ge;
    logic [CAP-1:0]                   occ;
    logic [CAP-1:0]                   ins;

    logic                             accept;
    snnl_pkg::cmd_t                   cmd;
    logic                             do_insert, do_read, do_clear;
    logic                             rotating;
    logic [snnl_pkg::POS_W-1:0]       pos;
    logic                             full_drop;
    logic [snnl_pkg::CNT_W-1:0]       read_n;
    logic [snnl_pkg::CNT_W-1:0]       rot_ext;
    logic                             rot_done;

    // Cell chain
    for (genvar g = 0; g < CAP; g++)
    begin : g_cell
        snnl_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl[g]),
            .new_dist  (distance),
            .new_idx   (candidate_index),
            .prev_dist ((g == 0) ? distance : c_dist[(g == 0) ? 0 : g - 1]),
            .prev_idx  ((g == 0) ? candidate_index : c_idx[(g == 0) ? 0 : g - 1]),
            .next_dist (c_dist[(g + 1) % CAP]),
            .next_idx  (c_idx[(g + 1) % CAP]),
            .held_dist (c_dist[g]),
            .held_idx  (c_idx[g]),
            .ge        (c_ge[g])
        );
    end

    // Decode the command
    assign accept = start && !busy;
    assign cmd    = snnl_pkg::cmd_t'(command);

    always_comb
    begin
        do_insert = 1'b0;
        do_read   = 1'b0;
        do_clear  = 1'b0;
        unique case (cmd)
            snnl_pkg::CMD_INSERT: do_insert = accept;
            snnl_pkg::CMD_READ:   do_read   = accept;
            snnl_pkg::CMD_CLEAR:  do_clear  = accept;
            default:
            begin
                do_insert = 1'b0;
                do_read   = 1'b0;
                do_clear  = 1'b0;
            end
        endcase
    end

    // Mark occupied cells and those at or after the insertion point
    always_comb
    begin
        for (int i = 0; i < CAP; i++)
        begin
            occ[i] = (snnl_pkg::CNT_W'(i) < count_reg);
            ins[i] = c_ge[i] || !occ[i];
        end
    end

    // Find the insertion point
    always_comb
    begin
        pos = '0;
        for (int i = CAP - 1; i >= 0; i--)
        begin
            if (ins[i])
            begin
                pos = snnl_pkg::POS_W'(i);
            end
        end
    end

    assign full_drop = !ins[CAP-1];

    // Read length and rotation progress
    assign read_n   = (count_reg > snnl_pkg::CNT_W'(snnl_pkg::READ_MAX))
                      ? snnl_pkg::CNT_W'(snnl_pkg::READ_MAX) : count_reg;
    assign rot_ext  = snnl_pkg::CNT_W'(rot_reg);
    assign rot_done = (rot_reg == snnl_pkg::POS_W'(CAP - 1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            snnl_pkg::ST_IDLE:
            begin
                if (do_read && (count_reg != '0))
                begin
                    state_next = snnl_pkg::ST_READ;
                end
            end
            snnl_pkg::ST_READ:
            begin
                if (rot_done)
                begin
                    state_next = snnl_pkg::ST_IDLE;
                end
            end
            default: state_next = snnl_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        busy     = 1'b0;
        rotating = 1'b0;
        unique case (state_reg)
            snnl_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                rotating = 1'b0;
            end
            snnl_pkg::ST_READ:
            begin
                busy     = 1'b1;
                rotating = 1'b1;
            end
            default:
            begin
                busy     = 1'b0;
                rotating = 1'b0;
            end
        endcase
    end

    // Drive the cells: rotate on read, shift on insert, else hold
    always_comb
    begin
        for (int i = 0; i < CAP; i++)
        begin
            ctrl[i].op = snnl_pkg::CELL_HOLD;
            if (rotating)
            begin
                ctrl[i].op = snnl_pkg::CELL_TAKE_NEXT;
            end
            else if (do_insert && !full_drop)
            begin
                if (ins[i] && ((i == 0) || !ins[(i == 0) ? 0 : i - 1]))
                begin
                    ctrl[i].op = snnl_pkg::CELL_LOAD_NEW;
                end
                else if ((i != 0) && ins[(i == 0) ? 0 : i - 1])
                begin
                    ctrl[i].op = snnl_pkg::CELL_TAKE_PREV;
                end
            end
        end
    end

    // Advance fill count and rotation counter
    always_comb
    begin
        count_next = count_reg;
        if (do_clear)
        begin
            count_next = '0;
        end
        else if (do_insert && !full_drop && (count_reg < snnl_pkg::CNT_W'(CAP)))
        begin
            count_next = count_reg + snnl_pkg::CNT_W'(1);
        end
        rot_next = rotating ? (rot_done ? '0 : rot_reg + snnl_pkg::POS_W'(1)) : '0;
    end

    // Build the next result
    always_comb
    begin
        strobe_next = 1'b0;
        valid_next  = 1'b0;
        rank_next   = '0;
        ridx_next   = '0;
        rdist_next  = '0;
        drop_next   = 1'b0;
        last_next   = 1'b1;
        if (rotating)
        begin
            strobe_next = (rot_ext < read_n);
            valid_next  = 1'b1;
            rank_next   = snnl_pkg::RANK_W'(rot_reg);
            ridx_next   = c_idx[0];
            rdist_next  = c_dist[0];
            last_next   = ((rot_ext + snnl_pkg::CNT_W'(1)) == read_n);
        end
        else if (do_insert)
        begin
            strobe_next = 1'b1;
            if (full_drop)
            begin
                drop_next = 1'b1;
            end
            else
            begin
                valid_next = 1'b1;
                rank_next  = snnl_pkg::RANK_W'(pos);
                ridx_next  = candidate_index;
                rdist_next = distance;
            end
        end
        else if (do_read && (count_reg == '0))
        begin
            strobe_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= snnl_pkg::ST_IDLE;
            count_reg  <= '0;
            rot_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rot_reg    <= rot_next;
            strobe_reg <= strobe_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        valid_reg <= valid_next;
        rank_reg  <= rank_next;
        ridx_reg  <= ridx_next;
        rdist_reg <= rdist_next;
        drop_reg  <= drop_next;
        last_reg  <= last_next;
    end

    assign strobe          = strobe_reg;
    assign entry_valid     = valid_reg;
    assign rank            = rank_reg;
    assign ranked_index    = ridx_reg;
    assign ranked_distance = rdist_reg;
    assign dropped         = drop_reg;
    assign last_of_run     = last_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= snnl_pkg::CNT_W'(CAP))
        else $error("fill count beyond capacity");

    a_insert_result: assert property (@(posedge clk) disable iff (!rst_n)
        do_insert |=> strobe && last_of_run && (dropped != entry_valid))
        else $error("insert did not give exactly one result");

    a_read_ranks: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last_of_run |=> strobe && (rank == 4'($past(rank) + 4'd1)))
        else $error("read ranks not consecutive");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        do_insert && full_drop |-> (count_reg == snnl_pkg::CNT_W'(CAP)))
        else $error("drop while list not full");

endmodule
